// File: sv/atan4l_pkg.sv
package atan4l_pkg;

   localparam int LANES        = 4;
   localparam int DIV_STAGES   = 32;
   localparam int POLY_STAGES  = 6;
   // Range reduction, divider, t formation, polynomial, final rounding.
   localparam int LANE_LATENCY = 1 + DIV_STAGES + 1 + POLY_STAGES + 1;

   typedef logic signed [35:0] q_type;

   typedef enum logic [1:0] {
      SEL_DIRECT,
      SEL_RATIO,
      SEL_RECIP
   } sel_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] lo;
      logic [31:0] q;
   } div_type;

   localparam logic [63:0] TH_HIGH = 64'd10368968295;
   localparam logic [63:0] TH_LOW  = 64'd1779033703;
   localparam q_type K_PI2 = 36'sd6746518852;
   localparam q_type K_PI4 = 36'sd3373259426;
   localparam q_type K_C4  = 36'sd345905692;
   localparam q_type K_C3  = 36'sd596042058;
   localparam q_type K_C2  = 36'sd858036139;
   localparam q_type K_C1  = 36'sd1431639265;

   // Sign-magnitude Q.32 product, rounded to nearest with halves away from zero.
   function automatic q_type qmul(q_type a, q_type b);
      logic [35:0] ma;
      logic [35:0] mb;
      logic [63:0] p;
      logic [31:0] r;
      q_type       pos;
      ma  = a[35] ? 36'(-a) : 36'(a);
      mb  = b[35] ? 36'(-b) : 36'(b);
      p   = 64'(ma[31:0]) * 64'(mb[31:0]);
      r   = 32'((p + 64'h0000_0000_8000_0000) >> 32);
      pos = q_type'({4'b0000, r});
      return (a[35] ^ b[35]) ? -pos : pos;
   endfunction

   // One restoring division step: bring down one numerator bit, emit one quotient bit.
   function automatic div_type div_step(div_type s, logic [31:0] den);
      logic [32:0] trial;
      div_type     n;
      trial = {s.rem, s.lo[31]};
      n.lo  = {s.lo[30:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         n.rem = 32'(trial - {1'b0, den});
         n.q   = {s.q[30:0], 1'b1};
      end else begin
         n.rem = trial[31:0];
         n.q   = {s.q[30:0], 1'b0};
      end
      return n;
   endfunction

endpackage

// File: sv/atan4l_divider.sv
module atan4l_divider
   import atan4l_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] num_hi,
   input  logic [31:0] num_lo,
   input  logic [31:0] den,
   output logic [31:0] quot
);

   // The upper numerator word is always below the divisor, so the quotient fits 32 bits.
   div_type     stage_ff [DIV_STAGES];
   logic [31:0] den_ff   [DIV_STAGES];

   always_ff @(posedge clock) begin
      stage_ff[0] <= div_step('{rem: num_hi, lo: num_lo, q: 32'd0}, den);
      den_ff[0]   <= den;
      for (int k = 1; k < DIV_STAGES; k++) begin
         stage_ff[k] <= div_step(stage_ff[k-1], den_ff[k-1]);
         den_ff[k]   <= den_ff[k-1];
      end
   end

   assign quot = stage_ff[DIV_STAGES-1].q;

endmodule

// File: sv/atan4l_lane.sv
module atan4l_lane
   import atan4l_pkg::*;
#(
   parameter int IN_FRAC_BITS  = 16,
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic        clock,
   input  logic [31:0] x,
   output logic [31:0] angle
);

   localparam logic [31:0] ONE      = 32'd1 << IN_FRAC_BITS;
   localparam int          AQ_SHIFT = 32 - IN_FRAC_BITS;
   localparam logic [35:0] RND      = 36'd1 << (31 - OUT_FRAC_BITS);
   localparam int          OUT_SH   = 32 - OUT_FRAC_BITS;

   // Range reduction.
   logic [31:0] x_mag;
   logic [30:0] a;
   logic [31:0] a_ext;
   logic [63:0] aq;
   logic [31:0] den_sum;
   sel_type     sel_in;
   logic        tneg_in;
   logic [31:0] hi_in, lo_in, den_in;

   always_comb begin
      x_mag   = x[31] ? 32'(32'd0 - x) : x;
      a       = x_mag[31] ? 31'h7FFF_FFFF : x_mag[30:0];
      a_ext   = {1'b0, a};
      aq      = 64'(a_ext) << AQ_SHIFT;
      den_sum = a_ext + ONE;
      tneg_in = a_ext < ONE;
      sel_in  = SEL_DIRECT;
      hi_in   = 32'd0;
      lo_in   = 32'd0;
      den_in  = 32'd1;
      if (aq > TH_HIGH) begin
         sel_in = SEL_RECIP;
         hi_in  = ONE;
         lo_in  = {2'b00, a[30:1]};
         den_in = a_ext;
      end else if (aq > TH_LOW) begin
         sel_in = SEL_RATIO;
         hi_in  = tneg_in ? 32'(ONE - a_ext) : 32'(a_ext - ONE);
         lo_in  = {1'b0, den_sum[31:1]};
         den_in = den_sum;
      end
   end

   logic        neg_r_ff, tneg_r_ff;
   sel_type     sel_r_ff;
   logic [30:0] tdir_r_ff;
   logic [31:0] hi_ff, lo_ff, den_ff;

   always_ff @(posedge clock) begin
      neg_r_ff  <= x[31];
      sel_r_ff  <= sel_in;
      tneg_r_ff <= tneg_in;
      tdir_r_ff <= aq[30:0];
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      den_ff    <= den_in;
   end

   logic [31:0] quot;

   atan4l_divider u_divider (
      .clock  (clock),
      .num_hi (hi_ff),
      .num_lo (lo_ff),
      .den    (den_ff),
      .quot   (quot)
   );

   logic        neg_d_ff  [DIV_STAGES];
   sel_type     sel_d_ff  [DIV_STAGES];
   logic        tneg_d_ff [DIV_STAGES];
   logic [30:0] tdir_d_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      neg_d_ff[0]  <= neg_r_ff;
      sel_d_ff[0]  <= sel_r_ff;
      tneg_d_ff[0] <= tneg_r_ff;
      tdir_d_ff[0] <= tdir_r_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         neg_d_ff[k]  <= neg_d_ff[k-1];
         sel_d_ff[k]  <= sel_d_ff[k-1];
         tneg_d_ff[k] <= tneg_d_ff[k-1];
         tdir_d_ff[k] <= tdir_d_ff[k-1];
      end
   end

   // Reduced argument and offset.
   q_type t_in, off_in, q_pos;

   always_comb begin
      q_pos = q_type'({4'b0000, quot});
      unique case (sel_d_ff[DIV_STAGES-1])
         SEL_RECIP: begin
            t_in   = -q_pos;
            off_in = K_PI2;
         end
         SEL_RATIO: begin
            t_in   = tneg_d_ff[DIV_STAGES-1] ? -q_pos : q_pos;
            off_in = K_PI4;
         end
         default: begin
            t_in   = q_type'({5'b00000, tdir_d_ff[DIV_STAGES-1]});
            off_in = '0;
         end
      endcase
   end

   // Horner evaluation, one product per stage.
   q_type t_p_ff   [POLY_STAGES];
   q_type off_p_ff [POLY_STAGES];
   logic  neg_p_ff [POLY_STAGES];
   q_type z_ff     [1:4];
   q_type acc_ff   [2:5];
   q_type y_ff;
   logic  neg_y_ff;

   always_ff @(posedge clock) begin
      t_p_ff[0]   <= t_in;
      off_p_ff[0] <= off_in;
      neg_p_ff[0] <= neg_d_ff[DIV_STAGES-1];
      for (int k = 1; k < POLY_STAGES; k++) begin
         t_p_ff[k]   <= t_p_ff[k-1];
         off_p_ff[k] <= off_p_ff[k-1];
         neg_p_ff[k] <= neg_p_ff[k-1];
      end
      z_ff[1] <= qmul(t_p_ff[0], t_p_ff[0]);
      for (int k = 2; k <= 4; k++) begin
         z_ff[k] <= z_ff[k-1];
      end
      acc_ff[2] <= qmul(K_C4, z_ff[1]) - K_C3;
      acc_ff[3] <= qmul(acc_ff[2], z_ff[2]) + K_C2;
      acc_ff[4] <= qmul(acc_ff[3], z_ff[3]) - K_C1;
      acc_ff[5] <= qmul(acc_ff[4], z_ff[4]);
      y_ff      <= off_p_ff[5] + qmul(acc_ff[5], t_p_ff[5]) + t_p_ff[5];
      neg_y_ff  <= neg_p_ff[5];
   end

   // Clamp, round to the output format, saturate, restore the sign.
   logic [35:0] y_clamp;
   logic [35:0] r;
   logic [31:0] r_sat;
   logic [31:0] angle_in;
   logic [31:0] angle_ff;

   always_comb begin
      y_clamp  = y_ff[35] ? 36'd0 : 36'(y_ff);
      r        = (y_clamp + RND) >> OUT_SH;
      r_sat    = (|r[35:31]) ? 32'h7FFF_FFFF : r[31:0];
      angle_in = neg_y_ff ? 32'(32'd0 - r_sat) : r_sat;
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

// File: sv/arctangent_four_lane.sv
// Four-lane fixed-point arctangent.
//
// An item is offered on req_x_lane0..req_x_lane3 (signed, IN_FRAC_BITS fraction bits)
// with start high; it is taken at any rising edge where start is high and busy is low.
// busy never rises, so one item may be taken on every clock cycle.
//
// Each lane reduces its argument by range, divides in a 32-stage pipelined divider
// (one quotient bit per stage), evaluates the odd polynomial with one product per
// stage, and rounds to OUT_FRAC_BITS fraction bits. All lanes run in lockstep and a
// merging register gathers their angles into one result item.
//
// Each result is shown on rsp_angle_lane0..rsp_angle_lane3 with rsp_valid high during
// exactly one cycle. An item passes the range-reduction register, the divider, whose
// depth sets most of the delay, and the t, polynomial, rounding and merging registers.
// The receiver cannot stall; results are never held back.
//
// A synchronous reset drops every item in flight; no result appears for them.
module arctangent_four_lane
   import atan4l_pkg::*;
#(
   parameter int IN_FRAC_BITS  = 16,
   parameter int OUT_FRAC_BITS = 30
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_lane0,
   input  logic signed [31:0] req_x_lane1,
   input  logic signed [31:0] req_x_lane2,
   input  logic signed [31:0] req_x_lane3,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_angle_lane0,
   output logic signed [31:0] rsp_angle_lane1,
   output logic signed [31:0] rsp_angle_lane2,
   output logic signed [31:0] rsp_angle_lane3
);

   // The pipeline accepts a new item every cycle, so it never pushes back.
   assign busy = 1'b0;

   logic [31:0] x_arr     [LANES];
   logic [31:0] angle_arr [LANES];

   assign x_arr[0] = req_x_lane0;
   assign x_arr[1] = req_x_lane1;
   assign x_arr[2] = req_x_lane2;
   assign x_arr[3] = req_x_lane3;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      atan4l_lane #(
         .IN_FRAC_BITS  (IN_FRAC_BITS),
         .OUT_FRAC_BITS (OUT_FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .x     (x_arr[i]),
         .angle (angle_arr[i])
      );
   end

   // The valid line follows each item through the lanes, which carry data only.
   logic [LANE_LATENCY-1:0] vld_ff;
   logic [LANE_LATENCY-1:0] vld_in;
   logic                    rsp_valid_ff;
   logic [31:0]             angle_out_ff [LANES];

   assign vld_in = {vld_ff[LANE_LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[LANE_LATENCY-1];
      end
   end

   // Merging stage: the four lane angles become one result item.
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         angle_out_ff[i] <= angle_arr[i];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle_lane0 = angle_out_ff[0];
   assign rsp_angle_lane1 = angle_out_ff[1];
   assign rsp_angle_lane2 = angle_out_ff[2];
   assign rsp_angle_lane3 = angle_out_ff[3];

endmodule

// File: sv/atan4l_checker.sv
module atan4l_checker
   import atan4l_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_x_lane0,
   input logic signed [31:0] req_x_lane1,
   input logic signed [31:0] req_x_lane2,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_angle_lane0,
   input logic signed [31:0] rsp_angle_lane1,
   input logic signed [31:0] rsp_angle_lane2
);

   localparam int LAT = LANE_LATENCY + 1;

   // Every result traces back to an item taken a fixed time earlier.
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching item");

   // A zero argument gives a zero angle.
   a_zero_in_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_x_lane0 == 32'sd0, LAT)) |-> (rsp_angle_lane0 == 32'sd0))
      else $error("zero argument gave a nonzero angle");

   // The angle keeps the sign of a positive argument.
   a_positive_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(!req_x_lane1[31] && req_x_lane1 != 32'sd0, LAT))
         |-> !rsp_angle_lane1[31])
      else $error("positive argument gave a negative angle");

   // A negative argument never gives a positive angle.
   a_negative_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_x_lane2[31], LAT))
         |-> (rsp_angle_lane2[31] || rsp_angle_lane2 == 32'sd0))
      else $error("negative argument gave a positive angle");

   // Reset drops all items in flight.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind arctangent_four_lane atan4l_checker u_atan4l_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_x_lane0     (req_x_lane0),
   .req_x_lane1     (req_x_lane1),
   .req_x_lane2     (req_x_lane2),
   .rsp_valid       (rsp_valid),
   .rsp_angle_lane0 (rsp_angle_lane0),
   .rsp_angle_lane1 (rsp_angle_lane1),
   .rsp_angle_lane2 (rsp_angle_lane2)
);
